>>> rtl/core/gf2css_pkg.sv
// Shared types and constants of the GF(2) CSS code checker.
`default_nettype none
package gf2css_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 6;
    localparam int ROW_W = 32;
    localparam int COUNT_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAB_X_ROWS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STAB_Z_ROWS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOGIC_X_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOGIC_Z_ROWS = 3'd4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [1:0] MAT_STAB_X  = 2'd0;
    localparam logic [1:0] MAT_STAB_Z  = 2'd1;
    localparam logic [1:0] MAT_LOGIC_X = 2'd2;
    localparam logic [1:0] MAT_LOGIC_Z = 2'd3;

    localparam logic [2:0] VERDICT_VALID    = 3'd0;
    localparam logic [2:0] VERDICT_XZ       = 3'd1;
    localparam logic [2:0] VERDICT_X_LZ     = 3'd2;
    localparam logic [2:0] VERDICT_Z_LX     = 3'd3;
    localparam logic [2:0] VERDICT_RANK_SUM = 3'd4;
    localparam logic [2:0] VERDICT_LOGIC    = 3'd5;

    typedef struct packed {
        logic        op;
        logic [1:0]  matrix_select;
        logic [4:0]  row_index;
        logic [31:0] row_bits;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic [5:0] rank_stab_x;
        logic [5:0] rank_stab_z;
        logic [5:0] rank_logic_x;
        logic [5:0] rank_logic_z;
    } out_beat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;        // write input row into store
        logic       pair_start;  // reset pair counters for product pair
        logic [1:0] mat_a;
        logic [1:0] mat_b;
        logic       rank_start;  // copy matrix into scratch, set up elimination
        logic [1:0] rank_mat;
        logic       fail_set;
        logic [2:0] fail_code;
        logic       finish;      // compute verdict into output register
    } dp_cmd_t;

    typedef struct packed {
        logic pair_done;
        logic pair_odd;   // an odd parity pair was seen
        logic rank_done;
    } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/core/gf2css_datapath.sv
// Datapath: row store, product pair walker, Gaussian elimination and result register.
`default_nettype none
module gf2css_datapath #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire gf2css_pkg::dp_cmd_t  cmd,
    output gf2css_pkg::dp_status_t    status,
    input  wire gf2css_pkg::in_beat_t in_beat,
    input  wire logic [5:0]           code_length,
    input  wire logic [5:0]           rows_x,
    input  wire logic [5:0]           rows_z,
    input  wire logic [5:0]           rows_lx,
    input  wire logic [5:0]           rows_lz,
    output gf2css_pkg::out_beat_t     result
);
    localparam int RI_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RC_W = $clog2(MAX_ROWS + 1);
    localparam int CI_W = $clog2(MAX_COLS);
    localparam int CC_W = $clog2(MAX_COLS + 1);
    localparam int ADDR_W = RI_W + 2;

    logic [MAX_COLS-1:0] store_mem [4*MAX_ROWS];
    logic [MAX_COLS-1:0] scratch_reg [MAX_ROWS];

    logic [CC_W-1:0] ncols;
    logic [MAX_COLS-1:0] mask;
    logic [RC_W-1:0] eff_rows [4];
    logic [5:0] raw_rows [4];

    always_comb begin
        raw_rows[0] = rows_x;
        raw_rows[1] = rows_z;
        raw_rows[2] = rows_lx;
        raw_rows[3] = rows_lz;
        for (int k = 0; k < 4; k++) begin
            if (32'(raw_rows[k]) > MAX_ROWS) begin
                eff_rows[k] = RC_W'(MAX_ROWS);
            end else begin
                eff_rows[k] = RC_W'(raw_rows[k]);
            end
        end
        if (32'(code_length) > MAX_COLS) begin
            ncols = CC_W'(MAX_COLS);
        end else begin
            ncols = CC_W'(code_length);
        end
        for (int c = 0; c < MAX_COLS; c++) begin
            mask[c] = (c < 32'(ncols));
        end
    end

    // Pair walk: one store read per cycle; row a held in a register.
    typedef enum logic [2:0] {
        PW_IDLE = 3'b001,
        PW_RDA  = 3'b010,
        PW_RDB  = 3'b100
    } pw_state_t;

    pw_state_t pw_reg, pw_next;
    logic [RC_W-1:0] pi_reg, pj_reg;
    logic [MAX_COLS-1:0] rowa_reg, rd_reg;
    logic pdone_reg, podd_reg, bvalid_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic rd_en;

    // Elimination: copy phase then column phase.
    typedef enum logic [3:0] {
        RK_IDLE  = 4'b0001,
        RK_COPY  = 4'b0010,
        RK_COL   = 4'b0100,
        RK_DONE  = 4'b1000
    } rk_state_t;

    rk_state_t rk_reg;
    logic [RC_W-1:0] cp_reg, rrows_reg, rank_reg;
    logic [CC_W-1:0] col_reg;
    logic [1:0] rmat_reg;
    logic cp_valid_reg;
    logic [RI_W-1:0] cp_wr_reg;
    logic [5:0] ranks_reg [4];
    logic [2:0] fail_reg;
    logic fail_seen_reg;

    always_comb begin
        rd_en = 1'b0;
        rd_addr = '0;
        if (pw_reg == PW_RDA && pi_reg < eff_rows[cmd.mat_a]) begin
            rd_en = 1'b1;
            rd_addr = {cmd.mat_a, pi_reg[RI_W-1:0]};
        end else if (pw_reg == PW_RDB && pj_reg < eff_rows[cmd.mat_b]) begin
            rd_en = 1'b1;
            rd_addr = {cmd.mat_b, pj_reg[RI_W-1:0]};
        end else if (rk_reg == RK_COPY && cp_reg < rrows_reg) begin
            rd_en = 1'b1;
            rd_addr = {rmat_reg, cp_reg[RI_W-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && 32'(in_beat.row_index) < MAX_ROWS) begin
            store_mem[{in_beat.matrix_select, RI_W'(in_beat.row_index)}] <=
                MAX_COLS'(in_beat.row_bits);
        end
        if (rd_en) begin
            rd_reg <= store_mem[rd_addr];
        end
    end

    // Pair walker control.
    always_comb begin
        pw_next = pw_reg;
        case (pw_reg)
            PW_IDLE: if (cmd.pair_start) pw_next = PW_RDA;
            PW_RDA:  pw_next = (pi_reg < eff_rows[cmd.mat_a]) ? PW_RDB : PW_IDLE;
            PW_RDB:  if (!(pj_reg < eff_rows[cmd.mat_b]) && !bvalid_reg) pw_next = PW_RDA;
            default: pw_next = PW_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_reg <= PW_IDLE;
            pdone_reg <= 1'b0;
            podd_reg <= 1'b0;
            bvalid_reg <= 1'b0;
        end else begin
            pw_reg <= pw_next;
            if (cmd.pair_start) begin
                pi_reg <= '0;
                pj_reg <= '0;
                pdone_reg <= 1'b0;
                podd_reg <= 1'b0;
                bvalid_reg <= 1'b0;
            end else begin
                case (pw_reg)
                    PW_RDA: begin
                        if (!(pi_reg < eff_rows[cmd.mat_a])) begin
                            pdone_reg <= 1'b1;
                        end
                        pj_reg <= '0;
                        bvalid_reg <= 1'b0;
                    end
                    PW_RDB: begin
                        if (pj_reg == '0 && !bvalid_reg && pi_reg < eff_rows[cmd.mat_a]) begin
                            rowa_reg <= rd_reg;
                        end
                        if (bvalid_reg && ^(rowa_reg & rd_reg & mask)) begin
                            podd_reg <= 1'b1;
                        end
                        if (pj_reg < eff_rows[cmd.mat_b]) begin
                            pj_reg <= pj_reg + 1'b1;
                            bvalid_reg <= 1'b1;
                        end else begin
                            bvalid_reg <= 1'b0;
                            if (!bvalid_reg) begin
                                pi_reg <= pi_reg + 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Elimination: pivot search over scratch rows is a priority pick, one column a cycle.
    logic [MAX_ROWS-1:0] hit;
    logic found;
    logic [RI_W-1:0] piv;
    logic [MAX_COLS-1:0] piv_row, rank_row;

    always_comb begin
        found = 1'b0;
        piv = '0;
        for (int i = 0; i < MAX_ROWS; i++) begin
            hit[i] = (i >= 32'(rank_reg)) && (i < 32'(rrows_reg)) &&
                     scratch_reg[i][col_reg[CI_W-1:0]];
        end
        for (int i = MAX_ROWS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                found = 1'b1;
                piv = RI_W'(i);
            end
        end
        piv_row = scratch_reg[piv];
        rank_row = scratch_reg[rank_reg[RI_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rk_reg <= RK_IDLE;
            cp_valid_reg <= 1'b0;
        end else begin
            case (rk_reg)
                RK_IDLE: begin
                    if (cmd.rank_start) begin
                        rk_reg <= RK_COPY;
                        rmat_reg <= cmd.rank_mat;
                        rrows_reg <= eff_rows[cmd.rank_mat];
                        cp_reg <= '0;
                        cp_valid_reg <= 1'b0;
                    end
                end
                RK_COPY: begin
                    if (cp_valid_reg) begin
                        scratch_reg[cp_wr_reg] <= rd_reg & mask;
                    end
                    cp_valid_reg <= (cp_reg < rrows_reg);
                    cp_wr_reg <= cp_reg[RI_W-1:0];
                    if (cp_reg < rrows_reg) begin
                        cp_reg <= cp_reg + 1'b1;
                    end else if (!cp_valid_reg) begin
                        rk_reg <= RK_COL;
                        col_reg <= '0;
                        rank_reg <= '0;
                    end
                end
                RK_COL: begin
                    if (col_reg >= ncols || rank_reg >= rrows_reg) begin
                        ranks_reg[rmat_reg] <= 6'(rank_reg);
                        rk_reg <= RK_DONE;
                    end else begin
                        if (found) begin
                            for (int i = 0; i < MAX_ROWS; i++) begin
                                if (i == 32'(rank_reg)) begin
                                    scratch_reg[i] <= piv_row;
                                end else if (RI_W'(i) == piv) begin
                                    scratch_reg[i] <= rank_row ^
                                        (rank_row[col_reg[CI_W-1:0]] ? piv_row : '0);
                                end else if (hit[i]) begin
                                    scratch_reg[i] <= scratch_reg[i] ^ piv_row;
                                end
                            end
                            rank_reg <= rank_reg + 1'b1;
                        end
                        col_reg <= col_reg + 1'b1;
                    end
                end
                RK_DONE: rk_reg <= RK_IDLE;
                default: rk_reg <= RK_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fail_seen_reg <= 1'b0;
            fail_reg <= gf2css_pkg::VERDICT_VALID;
        end else if (cmd.pair_start && cmd.mat_a == gf2css_pkg::MAT_STAB_X &&
                     cmd.mat_b == gf2css_pkg::MAT_STAB_Z) begin
            fail_seen_reg <= 1'b0;
            fail_reg <= gf2css_pkg::VERDICT_VALID;
        end else if (cmd.fail_set && !fail_seen_reg) begin
            fail_seen_reg <= 1'b1;
            fail_reg <= cmd.fail_code;
        end
    end

    logic [7:0] rsum;
    assign rsum = 8'(ranks_reg[0]) + 8'(ranks_reg[1]) + 8'(ranks_reg[2]);

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (fail_seen_reg) begin
                result.verdict <= fail_reg;
            end else if (rsum != 8'(ncols)) begin
                result.verdict <= gf2css_pkg::VERDICT_RANK_SUM;
            end else if (ranks_reg[2] != ranks_reg[3]) begin
                result.verdict <= gf2css_pkg::VERDICT_LOGIC;
            end else begin
                result.verdict <= gf2css_pkg::VERDICT_VALID;
            end
            result.rank_stab_x <= ranks_reg[0];
            result.rank_stab_z <= ranks_reg[1];
            result.rank_logic_x <= ranks_reg[2];
            result.rank_logic_z <= ranks_reg[3];
        end
    end

    assign status.pair_done = pdone_reg;
    assign status.pair_odd = podd_reg;
    assign status.rank_done = (rk_reg == RK_DONE);

endmodule
`default_nettype wire

>>> rtl/core/gf2css_ctrl.sv
// Controller state machine sequencing loads, product tests, ranks and the result beat.
`default_nettype none
module gf2css_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_op,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output gf2css_pkg::dp_cmd_t         cmd,
    input  wire gf2css_pkg::dp_status_t status
);
    typedef enum logic [7:0] {
        ST_IDLE    = 8'b00000001,
        ST_PAIR    = 8'b00000010,
        ST_PWAIT   = 8'b00000100,
        ST_RANK    = 8'b00001000,
        ST_RWAIT   = 8'b00010000,
        ST_FINISH  = 8'b00100000,
        ST_OUT     = 8'b01000000,
        ST_GAP     = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        m_valid_next = m_valid_reg;
        cmd = '0;
        s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
        case (step_reg)
            2'd0: begin
                cmd.mat_a = gf2css_pkg::MAT_STAB_X;
                cmd.mat_b = gf2css_pkg::MAT_STAB_Z;
                cmd.fail_code = gf2css_pkg::VERDICT_XZ;
            end
            2'd1: begin
                cmd.mat_a = gf2css_pkg::MAT_STAB_X;
                cmd.mat_b = gf2css_pkg::MAT_LOGIC_Z;
                cmd.fail_code = gf2css_pkg::VERDICT_X_LZ;
            end
            default: begin
                cmd.mat_a = gf2css_pkg::MAT_STAB_Z;
                cmd.mat_b = gf2css_pkg::MAT_LOGIC_X;
                cmd.fail_code = gf2css_pkg::VERDICT_Z_LX;
            end
        endcase
        cmd.rank_mat = step_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_op == gf2css_pkg::OP_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        step_next = 2'd0;
                        state_next = ST_PAIR;
                    end
                end
            end
            ST_PAIR: begin
                cmd.pair_start = 1'b1;
                state_next = ST_GAP;
            end
            ST_GAP: state_next = ST_PWAIT;
            ST_PWAIT: begin
                if (status.pair_done) begin
                    cmd.fail_set = status.pair_odd;
                    if (step_reg == 2'd2) begin
                        step_next = 2'd0;
                        state_next = ST_RANK;
                    end else begin
                        step_next = step_reg + 2'd1;
                        state_next = ST_PAIR;
                    end
                end
            end
            ST_RANK: begin
                cmd.rank_start = 1'b1;
                state_next = ST_RWAIT;
            end
            ST_RWAIT: begin
                if (status.rank_done) begin
                    if (step_reg == 2'd3) begin
                        state_next = ST_FINISH;
                    end else begin
                        step_next = step_reg + 2'd1;
                        state_next = ST_RANK;
                    end
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

>>> rtl/core/gf2_css_code_checker_top.sv
// Top level of the GF(2) CSS code checker: configuration registers, controller and datapath.
//
//   channel  direction  beat           handshake
//   s_       in         in_beat_t      s_valid / s_ready
//   m_       out        out_beat_t     m_valid / m_ready
//   cfg_     in         index, data    cfg_we only
//
// A load beat writes its row into the store. A check beat runs three product tests, each while
// the single store read port walks every row pair; then four rank passes, each walking the
// columns until the rank is complete; then the verdict is registered for the result beat.
// Reset is synchronous on aresetn. Input is held off while a check runs or a result waits.
`default_nettype none
module gf2_css_code_checker_top #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire gf2css_pkg::in_beat_t  s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output gf2css_pkg::out_beat_t      m_data,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [5:0]            cfg_data
);
    logic [5:0] code_length_reg, rows_x_reg, rows_z_reg, rows_lx_reg, rows_lz_reg;
    gf2css_pkg::dp_cmd_t cmd;
    gf2css_pkg::dp_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_length_reg <= 6'd32;
            rows_x_reg <= '0;
            rows_z_reg <= '0;
            rows_lx_reg <= '0;
            rows_lz_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                gf2css_pkg::REG_CODE_LENGTH:  code_length_reg <= cfg_data;
                gf2css_pkg::REG_STAB_X_ROWS:  rows_x_reg <= cfg_data;
                gf2css_pkg::REG_STAB_Z_ROWS:  rows_z_reg <= cfg_data;
                gf2css_pkg::REG_LOGIC_X_ROWS: rows_lx_reg <= cfg_data;
                gf2css_pkg::REG_LOGIC_Z_ROWS: rows_lz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    gf2css_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_data.op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    gf2css_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_beat     (s_data),
        .code_length (code_length_reg),
        .rows_x      (rows_x_reg),
        .rows_z      (rows_z_reg),
        .rows_lx     (rows_lx_reg),
        .rows_lz     (rows_lz_reg),
        .result      (m_data)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while a result waits");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.op == gf2css_pkg::OP_CHECK) |=> !s_ready)
        else $error("check beat did not block input");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> !m_valid)
        else $error("result beat repeated");

endmodule
`default_nettype wire
